FILE: src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Item, state and command types, round constants, initial hash values and a rotate function.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    BSEL_DATA,
    BSEL_PAD80,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      wr_en;
    byte_sel_e sel;
    logic      cnt_inc;
    logic      load;
    logic      round;
    logic      fold;
    logic      reinit;
  } dp_cmd_t;

  typedef struct packed {
    logic [6:0] fill;
    logic [5:0] rnd;
  } dp_stat_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loading, padding, the 64 rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sha256_pkg::in_item_t  in_item_i,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_idx_o,
  output sha256_pkg::dp_cmd_t        cmd_o,
  input  wire sha256_pkg::dp_stat_t  stat_i
);

  sha256_pkg::ctrl_state_e state_q, state_d;
  logic fin_q, fin_d;
  logic [2:0] idx_q, idx_d;
  logic acc;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_q != sha256_pkg::ST_IDLE);
  assign out_valid = (state_q == sha256_pkg::ST_EMIT);
  assign out_idx_o = idx_q;

  always_comb begin
    state_d = state_q;
    fin_d = fin_q;
    idx_d = idx_q;
    unique case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (acc) begin
          fin_d = in_item_i.end_of_message;
          if (in_item_i.has_byte && stat_i.fill == 7'd63) begin
            state_d = sha256_pkg::ST_COMP;
          end else if (in_item_i.end_of_message) begin
            state_d = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (stat_i.fill == 7'd63) state_d = sha256_pkg::ST_COMP;
      end
      sha256_pkg::ST_COMP: begin
        if (stat_i.rnd == 6'd63) state_d = sha256_pkg::ST_FOLD;
      end
      sha256_pkg::ST_FOLD: begin
        if (!fin_q) begin
          state_d = sha256_pkg::ST_IDLE;
        end else if (stat_i.fill == 7'd0) begin
          state_d = sha256_pkg::ST_PAD;
        end else begin
          state_d = sha256_pkg::ST_EMIT;
          idx_d = 3'd0;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (!out_stall) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) state_d = sha256_pkg::ST_IDLE;
        end
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  // fill != 0 after fold means the final block was just done (pad sets marker)
  always_comb begin
    cmd_o = '0;
    cmd_o.sel = sha256_pkg::BSEL_DATA;
    unique case (state_q)
      sha256_pkg::ST_IDLE: begin
        cmd_o.wr_en = acc && in_item_i.has_byte;
        cmd_o.cnt_inc = acc && in_item_i.has_byte;
        cmd_o.load = acc && in_item_i.has_byte && stat_i.fill == 7'd63;
      end
      sha256_pkg::ST_PAD: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.sel = sha256_pkg::BSEL_PAD80;
        cmd_o.load = (stat_i.fill == 7'd63);
      end
      sha256_pkg::ST_COMP: cmd_o.round = 1'b1;
      sha256_pkg::ST_FOLD: begin
        cmd_o.fold = 1'b1;
      end
      sha256_pkg::ST_EMIT: begin
        cmd_o.reinit = !out_stall && idx_q == 3'd7;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
      fin_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      state_q <= state_d;
      fin_q <= fin_d;
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/sha256_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte gathering into schedule words, padding bytes, round unit and chaining
// words.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           byte_i,
  input  wire sha256_pkg::dp_cmd_t  cmd_i,
  input  wire logic [2:0]           out_idx_i,
  output logic [31:0]               digest_o,
  output sha256_pkg::dp_stat_t      stat_o
);

  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q;
  logic        padded_q;
  logic        spill_q;
  logic        lenblk_n;
  logic [5:0]  rnd_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [7:0]  wbyte;
  logic [63:0] bits;
  logic [31:0] w_new, s0, s1, t1, t2, wk;
  logic [31:0] e, a;

  function automatic logic cnt_len_ok();
    return !(padded_q && lenblk_n);
  endfunction

  // spill_q: the 0x80 landed at 56..63, so this block carries no length
  assign lenblk_n = spill_q;

  // pad state: first pad write is 0x80, later zeros or length
  assign bits = {cnt_q, 3'b000};
  always_comb begin
    wbyte = byte_i;
    if (cmd_i.sel == sha256_pkg::BSEL_PAD80) begin
      if (!padded_q) wbyte = sha256_pkg::PadByte;
      else if (fill_q >= 6'd56 && cnt_len_ok()) wbyte = bits[8*(63-fill_q) +: 8];
      else wbyte = 8'h00;
    end
  end

  always_comb begin
    fill_d = fill_q + 6'd1;
  end

  assign w_new = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] :
                 (s1 + w_q[rnd_q[3:0] + 4'd9] + s0 + w_q[rnd_q[3:0]]);
  assign s1 = sha256_pkg::rotr(w_q[rnd_q[3:0] + 4'd14], 5'd17)
            ^ sha256_pkg::rotr(w_q[rnd_q[3:0] + 4'd14], 5'd19)
            ^ (w_q[rnd_q[3:0] + 4'd14] >> 10);
  assign s0 = sha256_pkg::rotr(w_q[rnd_q[3:0] + 4'd1], 5'd7)
            ^ sha256_pkg::rotr(w_q[rnd_q[3:0] + 4'd1], 5'd18)
            ^ (w_q[rnd_q[3:0] + 4'd1] >> 3);
  assign e = v_q[4];
  assign a = v_q[0];
  assign wk = w_new + sha256_pkg::RoundK[rnd_q];
  assign t1 = v_q[7] + (sha256_pkg::rotr(e, 5'd6) ^ sha256_pkg::rotr(e, 5'd11)
            ^ sha256_pkg::rotr(e, 5'd25)) + ((e & v_q[5]) ^ (~e & v_q[6])) + wk;
  assign t2 = (sha256_pkg::rotr(a, 5'd2) ^ sha256_pkg::rotr(a, 5'd13)
            ^ sha256_pkg::rotr(a, 5'd22)) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  // at fold: 1 when the length block is done, else 0 (a data block or another pad block follows)
  assign stat_o.fill = cmd_i.fold ? {6'd0, padded_q && !spill_q} : {1'b0, fill_q};
  assign stat_o.rnd = rnd_q;
  assign digest_o = h_q[out_idx_i];

  // bytes go straight into the schedule words; input is stalled during rounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wbyte;
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      w_q[rnd_q[3:0]] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q <= '0;
      padded_q <= 1'b0;
      spill_q <= 1'b0;
      rnd_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
    end else begin
      if (cmd_i.wr_en) fill_q <= fill_d;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 61'd1;
      if (cmd_i.wr_en && cmd_i.sel == sha256_pkg::BSEL_PAD80 && !padded_q) begin
        padded_q <= 1'b1;
        spill_q <= (fill_q >= 6'd56);
      end
      if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        if (padded_q) spill_q <= 1'b0;
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
        cnt_q <= '0;
        padded_q <= 1'b0;
        spill_q <= 1'b0;
        fill_q <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Hashes a byte stream, emitting eight digest words per message.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall, in_item_i): one byte per item, with
//   end_of_message on the last item; an item with no byte and the end flag
//   hashes the empty message.
//   out channel (out_valid/out_stall, out_item_o): eight digest words,
//   word_index 0..7, final_word on the last one.
// Input: bytes are taken back to back while idle; the 64th byte of a block
//   starts the rounds and the fold, set by the single shared round unit.
// Final item: padding writes one byte a cycle up to the end of the block
//   (and through an extra block when the length spills to it), then each
//   block is compressed and folded, then the eight digest words are output.
// in_stall is high while a block is compressed, padded or emitted.
// While the receiver stalls the current word is held.
// Reset loads the initial hash values and empties the block.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sha256_pkg::in_item_t  in_item_i,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sha256_pkg::out_item_t      out_item_o
);

  sha256_pkg::dp_cmd_t  cmd;
  sha256_pkg::dp_stat_t stat;
  logic [2:0]  idx;
  logic [31:0] dig;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_item_i,
    .out_valid, .out_stall, .out_idx_o(idx), .cmd_o(cmd), .stat_i(stat)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni, .byte_i(in_item_i.data_byte), .cmd_i(cmd),
    .out_idx_i(idx), .digest_o(dig), .stat_o(stat)
  );

  assign out_item_o.digest_word = dig;
  assign out_item_o.word_index = idx;
  assign out_item_o.final_word = (idx == 3'd7);

endmodule
`default_nettype wire

FILE: src/sha256_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the stream hasher core.
// ----------------------------------------------------------------------------
module sha256_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire sha256_pkg::out_item_t out_item_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |-> !out_valid) else $error("input taken during output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_item_o))
    else $error("stalled item changed");

  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_item_o.final_word == (out_item_o.word_index == 3'd7))
    else $error("final flag mismatch");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall && !out_item_o.final_word |=>
      out_valid && out_item_o.word_index == $past(out_item_o.word_index) + 3'd1)
    else $error("word order broken");

endmodule

bind sha256_stream_hasher_core sha256_chk u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .out_item_o
);
`default_nettype wire
